/* hdl/dre_pkg.sv */
// dre_pkg: shared types and constants for the decimal to roman encoder
// no dependencies
`timescale 1ns / 1ps

package dre_pkg;

    localparam int VALUE_W = 12;
    localparam int CHAR_W  = 8;
    localparam int STAT_W  = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

    // decimal positions, most significant first
    localparam logic [1:0] POS_TH = 2'd0;
    localparam logic [1:0] POS_HU = 2'd1;
    localparam logic [1:0] POS_TE = 2'd2;
    localparam logic [1:0] POS_ON = 2'd3;

    // numeral letters
    localparam logic [CHAR_W-1:0] CH_I = 8'h49;
    localparam logic [CHAR_W-1:0] CH_V = 8'h56;
    localparam logic [CHAR_W-1:0] CH_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_C = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D = 8'h44;
    localparam logic [CHAR_W-1:0] CH_M = 8'h4D;

    // classified item passed from front to back
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [1:0]        th;
        logic [3:0]        hu;
        logic [3:0]        te;
        logic [3:0]        on;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qwr;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qrd;

endpackage

/* hdl/dre_if.sv */
// dre_in_if / dre_out_if: valid-ready channels of the encoder
// depends on dre_pkg
`timescale 1ns / 1ps

interface dre_in_if;
    import dre_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dre_out_if;
    import dre_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic [STAT_W-1:0] status;

    modport source (output valid, output char_code, output last, output status,
                    input ready);
    modport sink   (input valid, input char_code, input last, input status,
                    output ready);
endinterface

/* hdl/dre_front.sv */
// dre_front: accepts values, classifies them and splits them into decimal digits
// depends on dre_pkg and dre_in_if
`timescale 1ns / 1ps

module dre_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dre_in_if.sink          i_in,
    output dre_pkg::t_qwr   o_wr,
    input  logic            i_full
);
    import dre_pkg::*;

    // wide enough that nine thousand does not wrap
    localparam int MULT_W = VALUE_W + 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_state;

    t_state               r_state;
    logic [VALUE_W-1:0]   r_rem;
    logic [1:0]           r_step;
    t_entry               r_entry;

    logic [3:0]           n_digit;
    logic [VALUE_W-1:0]   n_sub;
    logic [MULT_W-1:0]    n_mult;

    // multiple j of the unit weight of a position
    function automatic logic [MULT_W-1:0] unit_mult(input logic [1:0] step, input int j);
        case (step)
            POS_TH:  return MULT_W'(j * 1000);
            POS_HU:  return MULT_W'(j * 100);
            default: return MULT_W'(j * 10);
        endcase
    endfunction

    // one decimal digit per cycle: largest multiple not above the remainder
    always_comb begin
        n_digit = '0;
        n_sub   = '0;
        n_mult  = '0;
        for (int j = 1; j <= 9; j++) begin
            n_mult = unit_mult(r_step, j);
            if ({2'b00, r_rem} >= n_mult) begin
                n_digit = 4'(j);
                n_sub   = n_mult[VALUE_W-1:0];
            end
        end
    end

    assign i_in.ready  = (r_state == F_IDLE);
    assign o_wr.valid  = (r_state == F_PUSH);
    assign o_wr.entry  = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= POS_TH;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in.valid) begin
                        r_rem         <= i_in.value;
                        r_step        <= POS_TH;
                        r_entry.th    <= '0;
                        r_entry.hu    <= '0;
                        r_entry.te    <= '0;
                        r_entry.on    <= '0;
                        if (i_in.value == '0) begin
                            r_entry.status <= ST_ZERO;
                            r_state        <= F_PUSH;
                        end else if (i_in.value > VALUE_MAX) begin
                            r_entry.status <= ST_RANGE;
                            r_state        <= F_PUSH;
                        end else begin
                            r_entry.status <= ST_OK;
                            r_state        <= F_CONV;
                        end
                    end
                end
                F_CONV: begin
                    r_rem <= r_rem - n_sub;
                    case (r_step)
                        POS_TH: begin
                            r_entry.th <= n_digit[1:0];
                            r_step     <= POS_HU;
                        end
                        POS_HU: begin
                            r_entry.hu <= n_digit;
                            r_step     <= POS_TE;
                        end
                        default: begin
                            // remainder after the tens is the ones digit
                            r_entry.te <= n_digit;
                            r_entry.on <= 4'(r_rem - n_sub);
                            r_state    <= F_PUSH;
                        end
                    endcase
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/dre_queue.sv */
// dre_queue: short register queue between front and back
// depends on dre_pkg
`timescale 1ns / 1ps

module dre_queue #(
    parameter int DEPTH = 2     // at least 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dre_pkg::t_qwr   i_wr,
    output logic            o_full,
    output dre_pkg::t_qrd   o_rd,
    input  logic            i_pop
);
    import dre_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry              r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_cnt;

    logic                n_push;
    logic                n_pop;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.entry = r_mem[r_rd_ptr];

    assign n_push = i_wr.valid && !o_full;
    assign n_pop  = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (n_pop && !n_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/dre_back.sv */
// dre_back: walks queued digits, emits one numeral character per cycle unless stalled
// depends on dre_pkg and dre_out_if
`timescale 1ns / 1ps

module dre_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dre_pkg::t_qrd   i_rd,
    output logic            o_pop,
    dre_out_if.source       o_out
);
    import dre_pkg::*;

    logic              r_busy;
    t_entry            r_entry;
    logic [1:0]        r_pos;
    logic [1:0]        r_k;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic [STAT_W-1:0] r_status;

    logic [3:0]        n_digit;
    logic [2:0]        n_len;
    logic [CHAR_W-1:0] n_char;
    logic [CHAR_W-1:0] n_one;
    logic [CHAR_W-1:0] n_five;
    logic [CHAR_W-1:0] n_ten;
    logic [1:0]        n_next_pos;
    logic              n_more;
    logic              n_end;
    logic              n_emit;

    function automatic logic [3:0] digit_at(input t_entry e, input logic [1:0] pos);
        case (pos)
            POS_TH:  return {2'b00, e.th};
            POS_HU:  return e.hu;
            POS_TE:  return e.te;
            default: return e.on;
        endcase
    endfunction

    // number of characters a digit expands to
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        case (d)
            4'd1, 4'd5:             return 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9: return 3'd2;
            4'd3, 4'd7:             return 3'd3;
            4'd8:                   return 3'd4;
            default:                return 3'd0;
        endcase
    endfunction

    function automatic logic [1:0] first_pos(input t_entry e);
        logic [1:0] p;
        p = POS_ON;
        for (int i = 3; i >= 0; i--) begin
            if (digit_at(e, 2'(i)) != '0) begin
                p = 2'(i);
            end
        end
        return p;
    endfunction

    always_comb begin
        n_digit = digit_at(r_entry, r_pos);
        n_len   = digit_len(n_digit);
        case (r_pos)
            POS_TH: begin
                n_one  = CH_M;
                n_five = CH_M;
                n_ten  = CH_M;
            end
            POS_HU: begin
                n_one  = CH_C;
                n_five = CH_D;
                n_ten  = CH_M;
            end
            POS_TE: begin
                n_one  = CH_X;
                n_five = CH_L;
                n_ten  = CH_C;
            end
            default: begin
                n_one  = CH_I;
                n_five = CH_V;
                n_ten  = CH_X;
            end
        endcase

        // subtractive pairs, five-form first for six to eight
        if (n_digit == 4'd9) begin
            n_char = (r_k == '0) ? n_one : n_ten;
        end else if (n_digit == 4'd4) begin
            n_char = (r_k == '0) ? n_one : n_five;
        end else if (n_digit >= 4'd5) begin
            n_char = (r_k == '0) ? n_five : n_one;
        end else begin
            n_char = n_one;
        end

        n_next_pos = r_pos;
        n_more     = 1'b0;
        for (int i = 3; i >= 0; i--) begin
            if (2'(i) > r_pos && digit_at(r_entry, 2'(i)) != '0) begin
                n_next_pos = 2'(i);
                n_more     = 1'b1;
            end
        end

        n_end = (({1'b0, r_k} + 3'd1) == n_len);
    end

    assign n_emit = r_busy && (!r_out_valid || o_out.ready);
    assign o_pop  = !r_busy && i_rd.valid;

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;
    assign o_out.status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= POS_TH;
            r_k         <= '0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_entry <= i_rd.entry;
                r_pos   <= first_pos(i_rd.entry);
                r_k     <= '0;
            end

            if (n_emit) begin
                r_out_valid <= 1'b1;
                if (r_entry.status != ST_OK) begin
                    r_char   <= '0;
                    r_last   <= 1'b1;
                    r_status <= r_entry.status;
                    r_busy   <= 1'b0;
                end else begin
                    r_char   <= n_char;
                    r_last   <= n_end && !n_more;
                    r_status <= ST_OK;
                    if (n_end && !n_more) begin
                        r_busy <= 1'b0;
                    end else if (n_end) begin
                        r_pos <= n_next_pos;
                        r_k   <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* hdl/decimal_to_roman_encoder.sv */
// decimal_to_roman_encoder: top level, front classifier, queue and character back end
// depends on dre_pkg, dre_if, dre_front, dre_queue and dre_back
`timescale 1ns / 1ps

// usage
//   i_in carries one 12-bit value per item; o_out returns the roman numeral of
//   that value as upper-case ascii characters, one per item, with last set on
//   the final character. zero gives one item with status zero, values above
//   3999 one item with status out of range, both with char_code 0.
// path to the output
//   a value passes an accept step, three digit steps of the front divider
//   (skipped for zero or out of range values), a push into the queue, a load
//   in the back end and the output register before its first character is valid.
// throughput
//   the back end emits one character per cycle while o_out is ready, with a
//   load step per item between numerals; 3888 gives the longest numeral.
//   the front takes one value at a time and runs ahead through the queue.
// reset
//   synchronous, active low; clears the front state, the queue and the output
//   valid. a stalled o_out holds its item; the front keeps accepting until the
//   queue fills.
module decimal_to_roman_encoder #(
    parameter int Q_DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dre_in_if.sink   i_in,
    dre_out_if.source o_out
);
    import dre_pkg::*;

    t_qwr  wr;
    t_qrd  rd;
    logic  full;
    logic  pop;

    dre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_wr    (wr),
        .i_full  (full)
    );

    dre_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .o_rd    (rd),
        .i_pop   (pop)
    );

    dre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // special results close their run at once
    a_special_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> o_out.last)
        else $error("special status without last");

    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> (o_out.char_code == '0))
        else $error("special status with a character");

    a_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_OK) |->
        (o_out.char_code == CH_I || o_out.char_code == CH_V ||
         o_out.char_code == CH_X || o_out.char_code == CH_L ||
         o_out.char_code == CH_C || o_out.char_code == CH_D ||
         o_out.char_code == CH_M))
        else $error("character outside the numeral set");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

/* sim/decimal_to_roman_encoder_test.sv */
// decimal_to_roman_encoder_test: self-checking bench for the roman numeral encoder
// drives values through dre_in_if, checks characters on dre_out_if against typed probe rows and its own speller
// depends on dre_pkg, dre_if and decimal_to_roman_encoder
`timescale 1ns / 1ps

module decimal_to_roman_encoder_test;
    import dre_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 75;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_PROBES     = 25;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic [STAT_W-1:0] status;
    } t_numeral_char;

    // typed rows give the single result directly, the rest go through the speller
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [CHAR_W-1:0]  char_code;
        logic [STAT_W-1:0]  status;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;

    dre_in_if  in_ch ();
    dre_out_if out_ch ();

    decimal_to_roman_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_numeral_char     expected_chars[$];
    logic [CHAR_W-1:0] spelled[$];

    int errors        = 0;
    int cycles        = 0;
    int values_sent   = 0;
    int zero_sent     = 0;
    int range_sent    = 0;
    int chars_checked = 0;

    t_probe_row probe_rows [0:N_PROBES-1] = '{
        '{12'd0,    1'b1, 8'd0, ST_ZERO},
        '{12'd4000, 1'b1, 8'd0, ST_RANGE},
        '{12'd4095, 1'b1, 8'd0, ST_RANGE},
        '{12'd1,    1'b1, CH_I, ST_OK},
        '{12'd5,    1'b1, CH_V, ST_OK},
        '{12'd10,   1'b1, CH_X, ST_OK},
        '{12'd50,   1'b1, CH_L, ST_OK},
        '{12'd100,  1'b1, CH_C, ST_OK},
        '{12'd500,  1'b1, CH_D, ST_OK},
        '{12'd1000, 1'b1, CH_M, ST_OK},
        '{12'd3999, 1'b0, 8'd0, ST_OK},
        '{12'd3888, 1'b0, 8'd0, ST_OK},
        '{12'd4,    1'b0, 8'd0, ST_OK},
        '{12'd9,    1'b0, 8'd0, ST_OK},
        '{12'd40,   1'b0, 8'd0, ST_OK},
        '{12'd90,   1'b0, 8'd0, ST_OK},
        '{12'd400,  1'b0, 8'd0, ST_OK},
        '{12'd900,  1'b0, 8'd0, ST_OK},
        '{12'd3000, 1'b0, 8'd0, ST_OK},
        '{12'd1994, 1'b0, 8'd0, ST_OK},
        '{12'd2730, 1'b0, 8'd0, ST_OK},
        '{12'd1365, 1'b0, 8'd0, ST_OK},
        '{12'd2048, 1'b0, 8'd0, ST_OK},
        '{12'd444,  1'b0, 8'd0, ST_OK},
        '{12'd3,    1'b0, 8'd0, ST_OK}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one decimal digit in the letters of its position
    function automatic void spell_digit(input int d, input logic [CHAR_W-1:0] one,
                                        input logic [CHAR_W-1:0] five,
                                        input logic [CHAR_W-1:0] ten);
        int n;
        if (d == 9) begin
            spelled.push_back(one);
            spelled.push_back(ten);
        end else if (d == 4) begin
            spelled.push_back(one);
            spelled.push_back(five);
        end else begin
            n = d;
            if (n >= 5) begin
                spelled.push_back(five);
                n -= 5;
            end
            for (int i = 0; i < n; i++) spelled.push_back(one);
        end
    endfunction

    function automatic void predict_numeral(input logic [VALUE_W-1:0] value);
        int            v;
        t_numeral_char c;
        v = int'(value);
        if (v == 0 || v > int'(VALUE_MAX)) begin
            c.char_code = '0;
            c.last      = 1'b1;
            c.status    = (v == 0) ? ST_ZERO : ST_RANGE;
            expected_chars.push_back(c);
            return;
        end
        spelled.delete();
        for (int i = 0; i < v / 1000; i++) spelled.push_back(CH_M);
        spell_digit((v % 1000) / 100, CH_C, CH_D, CH_M);
        spell_digit((v % 100) / 10, CH_X, CH_L, CH_C);
        spell_digit(v % 10, CH_I, CH_V, CH_X);
        foreach (spelled[k]) begin
            c.char_code = spelled[k];
            c.last      = (k == spelled.size() - 1);
            c.status    = ST_OK;
            expected_chars.push_back(c);
        end
    endfunction

    // holds valid until the item is taken; returns in the step of acceptance
    task automatic send_value(input logic [VALUE_W-1:0] value, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        values_sent++;
        if (value == '0) zero_sent++;
        else if (value > VALUE_MAX) range_sent++;
    endtask

    // digits drawn from the subtractive and five-form corners
    function automatic logic [VALUE_W-1:0] corner_value();
        int picks [5] = '{0, 4, 5, 8, 9};
        int v;
        v = $urandom_range(0, 3) * 1000 + picks[$urandom_range(0, 4)] * 100
            + picks[$urandom_range(0, 4)] * 10 + picks[$urandom_range(0, 4)];
        return (v == 0) ? 12'd3888 : v[VALUE_W-1:0];
    endfunction

    // receiver: checks each taken character, then picks ready for the next cycle
    initial begin
        int            stall_left;
        int            phase_left;
        bit            calm;
        int            g;
        t_numeral_char want;
        stall_left = 0;
        phase_left = 0;
        calm       = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character: char_code %0h last %0b status %0d",
                           out_ch.char_code, out_ch.last, out_ch.status);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (out_ch.char_code !== want.char_code) begin
                        $error("char_code: expected %0h, got %0h", want.char_code,
                               out_ch.char_code);
                        errors++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, out_ch.last);
                        errors++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               out_ch.status);
                        errors++;
                    end
                end
            end
            if (phase_left == 0) begin
                calm       = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(20, 200);
            end else begin
                phase_left--;
            end
            if (calm) begin
                stall_left = 0;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    stall_left = g - 1;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk) cycles++;
        $display("timeout after %0d cycles, %0d characters outstanding", cycles,
                 expected_chars.size());
        $display("decimal_to_roman_encoder_test: errors");
        $finish;
    end

    initial begin
        t_numeral_char      c;
        logic [VALUE_W-1:0] v;
        int                 r;
        int                 calm_left;
        bit                 calm;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        calm_left   = 0;
        calm        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_PROBES; i++) begin
            send_value(probe_rows[i].value, pick_gap());
            if (probe_rows[i].typed) begin
                c.char_code = probe_rows[i].char_code;
                c.last      = 1'b1;
                c.status    = probe_rows[i].status;
                expected_chars.push_back(c);
            end else begin
                predict_numeral(probe_rows[i].value);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(5, 20);
            end else begin
                calm_left--;
            end
            r = $urandom_range(0, 99);
            if (r < 8) v = '0;
            else if (r < 16) v = VALUE_W'($urandom_range(4000, 4095));
            else if (r < 35) v = corner_value();
            else v = VALUE_W'($urandom_range(1, 3999));
            send_value(v, calm ? 0 : pick_gap());
            predict_numeral(v);
        end
        in_ch.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d values (%0d zero, %0d out of range), checked %0d characters",
                 values_sent, zero_sent, range_sent, chars_checked);
        $display("stalls and gaps on both channels, %0d mismatches", errors);
        if (errors == 0) begin
            $display("decimal_to_roman_encoder_test: clean");
        end else begin
            $display("decimal_to_roman_encoder_test: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/dre_pkg.sv
hdl/dre_if.sv
hdl/dre_front.sv
hdl/dre_queue.sv
hdl/dre_back.sv
hdl/decimal_to_roman_encoder.sv
sim/decimal_to_roman_encoder_test.sv
